>>> design/srl_pkg.sv
// Shared types, constants and helpers for the S-record loader.
package srl_pkg;

    // Target memory size and the address width that covers it
    localparam longint MEM_BYTES = 64'd4194304;
    localparam int ADDR_W = 22;
    localparam int SIZE_W = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'(MEM_BYTES - 64'd1);

    // ASCII codes the parser looks for
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_3  = 8'h33;

    typedef logic [ADDR_W-1:0] addr_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_WRITE    = 3'd0,
        KIND_DONE     = 3'd1,
        KIND_SKIPPED  = 3'd2,
        KIND_NOT_SREC = 3'd3,
        KIND_SUMMARY  = 3'd4
    } kind_t;

    // One input character
    typedef struct packed {
        logic [7:0] char_code;
        logic       file_end;
    } item_t;

    // One result item
    typedef struct packed {
        kind_t             result_kind;
        addr_t             mem_address;
        logic [7:0]        mem_byte;
        logic              checksum_bad;
        logic [SIZE_W-1:0] image_size;
        addr_t             min_address;
    } result_t;

    // Hex digit value; anything that is not a hex digit reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

>>> design/srl_if.sv
// Channel interfaces: character input, result output and register write.
interface srl_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       file_end;

    modport source (output valid, output char_code, output file_end, input ready);
    modport sink   (input valid, input char_code, input file_end, output ready);
endinterface

interface srl_result_if;
    logic                      valid;
    logic                      ready;
    srl_pkg::kind_t            result_kind;
    srl_pkg::addr_t            mem_address;
    logic [7:0]                mem_byte;
    logic                      checksum_bad;
    logic [srl_pkg::SIZE_W-1:0] image_size;
    srl_pkg::addr_t            min_address;

    modport source (output valid, output result_kind, output mem_address,
                    output mem_byte, output checksum_bad, output image_size,
                    output min_address, input ready);
    modport sink   (input valid, input result_kind, input mem_address,
                    input mem_byte, input checksum_bad, input image_size,
                    input min_address, output ready);
endinterface

interface srl_cfg_if;
    logic valid;
    logic ready;
    logic checksum_check_enable;

    modport source (output valid, output checksum_check_enable, input ready);
    modport sink   (input valid, input checksum_check_enable, output ready);
endinterface

>>> design/s_record_loader_top.sv
// Top level of the S-record loader.
//
// Usage:
//   chars   - one ASCII character per transfer; file_end = 1 closes the file
//             (character ignored) and yields a summary, or not-an-S-record.
//   results - byte writes, record done/skipped, not-an-S-record and file
//             summary, at most one per character.
//   cfg     - writes checksum_check_enable; always ready, write while idle.
// Path: a transferred character loads the input register, the parser works
// on it and its result loads the result register that drives results.
// Throughput: one character per cycle while results are taken; the parser
// does a nibble shift, one 8-bit add and one 23-bit compare per character.
// The input register takes a new character while a result waits, as long
// as the result register is free or being emptied; when the receiver
// stalls with a result held, the parser holds and chars.ready drops after
// at most one more character.
// Reset clears the parser to start of line, lowest address to the last
// memory byte, highest to zero, and the checksum check to disabled.
module s_record_loader_top (
    input  logic         clk,
    input  logic         rst_n,
    srl_item_if.sink     chars,
    srl_result_if.source results,
    srl_cfg_if.sink      cfg
);

    logic             item_valid;
    srl_pkg::item_t   item;
    logic             can_load;
    logic             go;
    logic             res_valid;
    srl_pkg::result_t res;
    logic             chk_en_reg;

    // Parser advances when a character is held and the result slot is free
    assign go = item_valid && can_load;

    // Checksum check enable register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_en_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            chk_en_reg <= cfg.checksum_check_enable;
        end
    end

    srl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .take       (go),
        .item_valid (item_valid),
        .item       (item)
    );

    srl_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .item      (item),
        .chk_en    (chk_en_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    srl_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (go && res_valid),
        .res      (res),
        .can_load (can_load),
        .results  (results)
    );

endmodule

>>> design/srl_in_stage.sv
// Input register: holds one character until the parser consumes it.
module srl_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    srl_item_if.sink        chars,
    input  logic            take,
    output logic            item_valid,
    output srl_pkg::item_t  item
);

    logic           vld_reg;
    srl_pkg::item_t item_reg;

    // Open when empty or when the held character moves on this cycle
    assign chars.ready = !vld_reg || take;
    assign item_valid  = vld_reg;
    assign item        = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            vld_reg <= chars.valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            item_reg.char_code <= chars.char_code;
            item_reg.file_end  <= chars.file_end;
        end
    end

endmodule

>>> design/srl_parser.sv
// Record parser: line state machine, address and checksum tracking.
module srl_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  srl_pkg::item_t   item,
    input  logic             chk_en,
    output logic             res_valid,
    output srl_pkg::result_t res
);

    typedef enum logic [7:0] {
        PH_LINE_START = 8'b0000_0001,
        PH_TYPE       = 8'b0000_0010,
        PH_COUNT      = 8'b0000_0100,
        PH_ADDRESS    = 8'b0000_1000,
        PH_DATA       = 8'b0001_0000,
        PH_CHECKSUM   = 8'b0010_0000,
        PH_SKIP       = 8'b0100_0000,
        PH_FAILED     = 8'b1000_0000
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [1:0]     type_reg, type_next;
    logic [3:0]     pend_reg, pend_next;
    srl_pkg::addr_t acc_reg, acc_next;
    srl_pkg::addr_t wptr_reg, wptr_next;
    logic [7:0]     left_reg, left_next;
    logic [7:0]     bcount_reg, bcount_next;
    logic [7:0]     sum_reg, sum_next;
    srl_pkg::addr_t low_reg, low_next;
    srl_pkg::addr_t high_reg, high_next;
    logic           failed_reg, failed_next;

    // Next state and result for the held character
    always_comb
    begin
        logic [7:0]              c;
        logic [3:0]              nib;
        logic [7:0]              pair;
        logic [3:0]              cnt_inc;
        srl_pkg::addr_t          phys;
        logic [7:0]              needed;
        logic [7:0]              n;
        logic [srl_pkg::SIZE_W-1:0] end_addr;
        srl_pkg::addr_t          last_addr;

        c        = item.char_code;
        nib      = srl_pkg::hex_value(c);
        pair     = {pend_reg, nib};
        cnt_inc  = cnt_reg + 4'd1;
        phys     = {acc_reg[srl_pkg::ADDR_W-5:0], nib};
        needed   = {6'd0, type_reg} + 8'd2;
        n        = bcount_reg - needed;
        end_addr = {1'b0, phys} + srl_pkg::SIZE_W'(n);
        last_addr = phys + srl_pkg::ADDR_W'(n) - srl_pkg::ADDR_W'(1);

        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        type_next   = type_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        wptr_next   = wptr_reg;
        left_next   = left_reg;
        bcount_next = bcount_reg;
        sum_next    = sum_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        failed_next = failed_reg;

        res_valid          = 1'b0;
        res.result_kind    = srl_pkg::KIND_WRITE;
        res.mem_address    = '0;
        res.mem_byte       = '0;
        res.checksum_bad   = 1'b0;
        res.image_size     = '0;
        res.min_address    = low_reg;

        if (item.file_end)
        begin
            // File end: report, then back to the reset state
            res_valid = 1'b1;
            if (failed_reg)
            begin
                res.result_kind = srl_pkg::KIND_NOT_SREC;
            end
            else
            begin
                res.result_kind = srl_pkg::KIND_SUMMARY;
                res.image_size  = {1'b0, high_reg} + srl_pkg::SIZE_W'(1);
            end
            phase_next  = PH_LINE_START;
            cnt_next    = '0;
            type_next   = '0;
            pend_next   = '0;
            acc_next    = '0;
            wptr_next   = '0;
            left_next   = '0;
            bcount_next = '0;
            sum_next    = '0;
            low_next    = srl_pkg::ADDR_MASK;
            high_next   = '0;
            failed_next = 1'b0;
        end
        else if (phase_reg == PH_FAILED || c == srl_pkg::CH_CR)
        begin
            // nothing
        end
        else if (c == srl_pkg::CH_LF)
        begin
            phase_next = PH_LINE_START;
            cnt_next   = '0;
        end
        else
        begin
            case (phase_reg)
                PH_LINE_START:
                begin
                    if (c == srl_pkg::CH_S)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        failed_next     = 1'b1;
                        phase_next      = PH_FAILED;
                        res_valid       = 1'b1;
                        res.result_kind = srl_pkg::KIND_NOT_SREC;
                    end
                end
                PH_TYPE:
                begin
                    if (c >= srl_pkg::CH_1 && c <= srl_pkg::CH_3)
                    begin
                        type_next  = c[1:0];
                        phase_next = PH_COUNT;
                        cnt_next   = '0;
                        sum_next   = '0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        type_next  = '0;
                        phase_next = PH_SKIP;
                    end
                end
                PH_COUNT:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        pend_next = nib;
                        cnt_next  = 4'd1;
                    end
                    else
                    begin
                        cnt_next    = '0;
                        bcount_next = pair;
                        sum_next    = sum_reg + pair;
                        phase_next  = PH_ADDRESS;
                    end
                end
                PH_ADDRESS:
                begin
                    acc_next = phys;
                    cnt_next = cnt_inc;
                    if (!cnt_reg[0])
                    begin
                        pend_next = nib;
                    end
                    else
                    begin
                        sum_next = sum_reg + pair;
                    end
                    // Last address nibble: range check
                    if (cnt_inc == {1'b0, type_reg, 1'b0} + 4'd2)
                    begin
                        cnt_next = '0;
                        if (bcount_reg < needed
                            || end_addr > {1'b0, srl_pkg::ADDR_MASK})
                        begin
                            phase_next      = PH_SKIP;
                            res_valid       = 1'b1;
                            res.result_kind = srl_pkg::KIND_SKIPPED;
                            res.mem_address = phys;
                        end
                        else
                        begin
                            wptr_next = phys;
                            left_next = n;
                            if (n != 8'd0)
                            begin
                                if (phys < low_reg)
                                begin
                                    low_next = phys;
                                end
                                if (last_addr > high_reg)
                                begin
                                    high_next = last_addr;
                                end
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                phase_next = PH_CHECKSUM;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        pend_next = nib;
                        cnt_next  = 4'd1;
                    end
                    else
                    begin
                        cnt_next        = '0;
                        sum_next        = sum_reg + pair;
                        wptr_next       = wptr_reg + srl_pkg::ADDR_W'(1);
                        left_next       = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                        res_valid       = 1'b1;
                        res.result_kind = srl_pkg::KIND_WRITE;
                        res.mem_address = wptr_reg;
                        res.mem_byte    = pair;
                    end
                end
                PH_CHECKSUM:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        pend_next = nib;
                        cnt_next  = 4'd1;
                    end
                    else
                    begin
                        cnt_next         = '0;
                        phase_next       = PH_SKIP;
                        res_valid        = 1'b1;
                        res.result_kind  = srl_pkg::KIND_DONE;
                        res.checksum_bad = chk_en && (pair != ~sum_reg);
                    end
                end
                default:
                begin
                    // skip rest of line
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LINE_START;
            cnt_reg    <= '0;
            type_reg   <= '0;
            pend_reg   <= '0;
            acc_reg    <= '0;
            wptr_reg   <= '0;
            left_reg   <= '0;
            bcount_reg <= '0;
            sum_reg    <= '0;
            low_reg    <= srl_pkg::ADDR_MASK;
            high_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (go)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            type_reg   <= type_next;
            pend_reg   <= pend_next;
            acc_reg    <= acc_next;
            wptr_reg   <= wptr_next;
            left_reg   <= left_next;
            bcount_reg <= bcount_next;
            sum_reg    <= sum_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            failed_reg <= failed_next;
        end
    end

    // Checks
    a_failed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAILED |-> failed_reg)
        else $error("failed phase without failed flag");

    a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == srl_pkg::KIND_WRITE && !item.file_end
        |-> phase_reg == PH_DATA)
        else $error("byte write outside data phase");

    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != 8'd0)
        else $error("data phase with no bytes left");

    a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && item.file_end |=> phase_reg == PH_LINE_START && !failed_reg
        && low_reg == srl_pkg::ADDR_MASK)
        else $error("file end did not clear state");

endmodule

>>> design/srl_out_stage.sv
// Result register: holds one result until the receiver takes it.
module srl_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  srl_pkg::result_t res,
    output logic             can_load,
    srl_result_if.source     results
);

    logic             vld_reg;
    srl_pkg::result_t res_reg;

    assign can_load = !vld_reg || results.ready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (can_load)
        begin
            vld_reg <= load;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            res_reg <= res;
        end
    end

    assign results.valid          = vld_reg;
    assign results.result_kind    = res_reg.result_kind;
    assign results.mem_address    = res_reg.mem_address;
    assign results.mem_byte       = res_reg.mem_byte;
    assign results.checksum_bad   = res_reg.checksum_bad;
    assign results.image_size     = res_reg.image_size;
    assign results.min_address    = res_reg.min_address;

endmodule
